// File: sv/abpg_pkg.sv
// Shared constants and helper for the alarm beep pattern generator.
// No dependencies; used by alarm_beep_pattern_generator.
package abpg_pkg;

    localparam int unsigned NumSources = 9;
    localparam int unsigned SrcW       = 4;
    localparam int unsigned CfgIdxW    = 2;
    localparam int unsigned CfgDataW   = 16;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_BATT_MIN  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_BATT_WARN = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_DEB_LIMIT = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_BEEP_EN   = 2'd3;

    // Beep sources, lowest index has priority
    localparam logic [SrcW-1:0] SRC_INIT     = 4'd0;
    localparam logic [SrcW-1:0] SRC_GYRO     = 4'd1;
    localparam logic [SrcW-1:0] SRC_ACC      = 4'd2;
    localparam logic [SrcW-1:0] SRC_ADC      = 4'd3;
    localparam logic [SrcW-1:0] SRC_BATT     = 4'd4;
    localparam logic [SrcW-1:0] SRC_COMPASS  = 4'd5;
    localparam logic [SrcW-1:0] SRC_STRENGTH = 4'd6;
    localparam logic [SrcW-1:0] SRC_INCLINE  = 4'd7;
    localparam logic [SrcW-1:0] SRC_GPS      = 4'd8;
    localparam logic [SrcW-1:0] SRC_NONE     = 4'd9;

    // beep_enables bits
    localparam int unsigned EN_GPS   = 0;
    localparam int unsigned EN_FAULT = 1;
    localparam int unsigned EN_MAG   = 2;
    localparam int unsigned EN_INIT  = 3;

    localparam logic [7:0]  PatternLast = 8'd199;
    localparam logic [6:0]  PhaseLast   = 7'd99;
    localparam logic [7:0]  PhaseLen    = 8'd100;
    localparam logic [8:0]  WarnLimit   = 9'd400;
    localparam logic [15:0] DebFloor    = 16'd10;
    localparam logic [7:0]  GpsLock     = 8'd3;
    localparam logic [11:0] GpsModeMin  = 12'd200;
    localparam logic [3:0]  DefBeepEn   = 4'hF;
    localparam logic [15:0] DefDebLimit = 16'd20;

    // On for 5 ticks, off for 5, starting at 0, below slot_end (at most 50).
    function automatic logic burst(input logic [6:0] m, input logic [6:0] slot_end);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 5; k++) begin
            if (m >= 7'(10 * k) && m < 7'(10 * k + 5)) begin
                hit = 1'b1;
            end
        end
        return hit && (m < slot_end);
    endfunction

endpackage

// File: sv/alarm_beep_pattern_generator.sv
// Alarm beep pattern generator top level: tick state, source patterns, priority pick.
// Depends on abpg_pkg.
//
//  channel   signals                                   direction
//  -------   ---------------------------------------   ---------
//  tick in   i_valid / o_stall, i_battery_voltage ...  in
//  beep out  o_valid / i_stall, o_buzzer_on,           out
//            o_winning_source
//  config    i_cfg_wr_en, i_cfg_index, i_cfg_wr_data   in
//
// One tick per clock while o_stall is low. State updates at the input transfer, and the
// result is registered at the same edge. The output register is the only buffer, so a
// tick is taken whenever it is empty or being drained in the same cycle.
// Synchronous active-low reset clears all counters and restores register defaults.
module alarm_beep_pattern_generator #(
    parameter int unsigned BATTERY_STEP_DIVISOR = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [abpg_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [abpg_pkg::CfgDataW-1:0]       i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [15:0]                         i_battery_voltage,
    input  logic                                i_gyro_cal_error,
    input  logic                                i_acc_cal_error,
    input  logic                                i_adc_start_error,
    input  logic                                i_compass_fail,
    input  logic                                i_mag_strength_error,
    input  logic                                i_mag_incline_error,
    input  logic                                i_system_ready,
    input  logic [7:0]                          i_gps_status,
    input  logic [11:0]                         i_mode_channel,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_buzzer_on,
    output logic [abpg_pkg::SrcW-1:0]           o_winning_source
);

    localparam int unsigned DivW = $clog2(BATTERY_STEP_DIVISOR + 1);
    localparam int unsigned PrW  = 7 + DivW;
    localparam int unsigned CmpW = (PrW > 16) ? PrW : 16;
    localparam logic [DivW-1:0] DivC = DivW'(BATTERY_STEP_DIVISOR);

    // configuration
    logic [15:0] r_batt_min, r_batt_warn, r_deb_limit;
    logic [3:0]  r_beep_en;

    // tick state
    logic [7:0]  r_pattern, n_pattern;
    logic [6:0]  r_phase, n_phase;
    logic [15:0] r_debounce, n_debounce;
    logic        r_low_en, n_low_en;
    logic [8:0]  r_compass_ticks, n_compass_ticks;
    logic [8:0]  r_strength_ticks, n_strength_ticks;
    logic [8:0]  r_incline_ticks, n_incline_ticks;

    // result register
    logic                      r_valid;
    logic                      r_buzzer, n_buzzer;
    logic [abpg_pkg::SrcW-1:0] r_winner, n_winner;

    logic        in_xfer;
    logic [6:0]  m;
    logic [15:0] vbat, vdelta;
    logic        batt_low;
    logic [PrW-1:0] phase_scaled;
    logic        fault_on, mag_on;
    logic [abpg_pkg::NumSources-1:0] req, act;

    assign o_stall = r_valid && i_stall;
    assign in_xfer = i_valid && !o_stall;

    always_comb begin
        n_pattern = (r_pattern == abpg_pkg::PatternLast) ? 8'd0 : r_pattern + 8'd1;
        n_phase   = (r_phase == abpg_pkg::PhaseLast) ? 7'd0 : r_phase + 7'd1;
        m = (n_pattern >= abpg_pkg::PhaseLen) ? 7'(n_pattern - abpg_pkg::PhaseLen)
                                              : n_pattern[6:0];

        req = '0;
        act = '0;

        // battery: clamp, debounce with hysteresis, step pattern from headroom
        vbat     = (i_battery_voltage < r_batt_min) ? r_batt_min : i_battery_voltage;
        vdelta   = vbat - r_batt_min;
        batt_low = vbat < r_batt_warn;
        n_debounce = r_debounce;
        n_low_en   = r_low_en;
        if (batt_low) begin
            if (r_debounce < r_deb_limit) begin
                n_debounce = r_debounce + 16'd1;
            end else begin
                n_low_en = 1'b1;
            end
        end else begin
            if (r_debounce > abpg_pkg::DebFloor) begin
                n_debounce = r_debounce - 16'd2;
            end else begin
                n_low_en = 1'b0;
            end
        end
        // phase > delta / DIV  <=>  delta < phase * DIV
        phase_scaled = PrW'(n_phase) * PrW'(DivC);
        if (n_low_en) begin
            req[abpg_pkg::SRC_BATT] = 1'b1;
            act[abpg_pkg::SRC_BATT] = CmpW'(vdelta) < CmpW'(phase_scaled);
        end

        // gps
        if (r_beep_en[abpg_pkg::EN_GPS] && i_gps_status != abpg_pkg::GpsLock
                && i_mode_channel > abpg_pkg::GpsModeMin) begin
            req[abpg_pkg::SRC_GPS] = 1'b1;
            act[abpg_pkg::SRC_GPS] = n_pattern < 8'd5;
        end

        // calibration / converter faults, long windows from count 0
        fault_on = r_beep_en[abpg_pkg::EN_FAULT] && i_system_ready;
        if (fault_on && i_gyro_cal_error) begin
            req[abpg_pkg::SRC_GYRO] = 1'b1;
            act[abpg_pkg::SRC_GYRO] = n_pattern < 8'd155
                || (n_pattern >= 8'd160 && n_pattern < 8'd165);
        end
        if (fault_on && i_acc_cal_error) begin
            req[abpg_pkg::SRC_ACC] = 1'b1;
            act[abpg_pkg::SRC_ACC] = n_pattern < 8'd145
                || (n_pattern >= 8'd150 && n_pattern < 8'd155)
                || (n_pattern >= 8'd160 && n_pattern < 8'd165);
        end
        if (fault_on && i_adc_start_error) begin
            req[abpg_pkg::SRC_ADC] = 1'b1;
            act[abpg_pkg::SRC_ADC] = n_pattern < 8'd135
                || (n_pattern >= 8'd140 && n_pattern < 8'd145)
                || (n_pattern >= 8'd150 && n_pattern < 8'd155)
                || (n_pattern >= 8'd160 && n_pattern < 8'd165);
        end

        // magnetometer one-shot warnings
        mag_on = fault_on && r_beep_en[abpg_pkg::EN_MAG];
        n_compass_ticks  = r_compass_ticks;
        n_strength_ticks = r_strength_ticks;
        n_incline_ticks  = r_incline_ticks;
        if (mag_on && i_compass_fail && r_compass_ticks < abpg_pkg::WarnLimit) begin
            req[abpg_pkg::SRC_COMPASS] = 1'b1;
            act[abpg_pkg::SRC_COMPASS] = abpg_pkg::burst(m, 7'd50);
            n_compass_ticks = r_compass_ticks + 9'd1;
        end
        if (mag_on && i_mag_strength_error && r_strength_ticks < abpg_pkg::WarnLimit) begin
            req[abpg_pkg::SRC_STRENGTH] = 1'b1;
            act[abpg_pkg::SRC_STRENGTH] = abpg_pkg::burst(m, 7'd30);
            n_strength_ticks = r_strength_ticks + 9'd1;
        end
        if (mag_on && i_mag_incline_error && r_incline_ticks < abpg_pkg::WarnLimit) begin
            req[abpg_pkg::SRC_INCLINE] = 1'b1;
            act[abpg_pkg::SRC_INCLINE] = abpg_pkg::burst(m, 7'd40);
            n_incline_ticks = r_incline_ticks + 9'd1;
        end

        // init
        if (r_beep_en[abpg_pkg::EN_INIT] && !i_system_ready) begin
            req[abpg_pkg::SRC_INIT] = 1'b1;
            act[abpg_pkg::SRC_INIT] = abpg_pkg::burst(m, 7'd15);
        end

        // lowest requesting source wins
        n_winner = abpg_pkg::SRC_NONE;
        n_buzzer = 1'b0;
        for (int i = abpg_pkg::NumSources - 1; i >= 0; i--) begin
            if (req[i]) begin
                n_winner = abpg_pkg::SrcW'(i);
                n_buzzer = act[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batt_min  <= '0;
            r_batt_warn <= '0;
            r_deb_limit <= abpg_pkg::DefDebLimit;
            r_beep_en   <= abpg_pkg::DefBeepEn;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                abpg_pkg::CFG_BATT_MIN:  r_batt_min  <= i_cfg_wr_data;
                abpg_pkg::CFG_BATT_WARN: r_batt_warn <= i_cfg_wr_data;
                abpg_pkg::CFG_DEB_LIMIT: r_deb_limit <= i_cfg_wr_data;
                abpg_pkg::CFG_BEEP_EN:   r_beep_en   <= i_cfg_wr_data[3:0];
                default:                 r_beep_en   <= r_beep_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern        <= '0;
            r_phase          <= '0;
            r_debounce       <= '0;
            r_low_en         <= 1'b0;
            r_compass_ticks  <= '0;
            r_strength_ticks <= '0;
            r_incline_ticks  <= '0;
        end else if (in_xfer) begin
            r_pattern        <= n_pattern;
            r_phase          <= n_phase;
            r_debounce       <= n_debounce;
            r_low_en         <= n_low_en;
            r_compass_ticks  <= n_compass_ticks;
            r_strength_ticks <= n_strength_ticks;
            r_incline_ticks  <= n_incline_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_xfer) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_buzzer <= n_buzzer;
            r_winner <= n_winner;
        end
    end

    assign o_valid          = r_valid;
    assign o_buzzer_on      = r_buzzer;
    assign o_winning_source = r_winner;

endmodule
